// ----- design/delimited_token_splitter_defines.svh -----
// Assertion helpers for the tokenizer RTL
`ifndef DELIMITED_TOKEN_SPLITTER_DEFINES_SVH
`define DELIMITED_TOKEN_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define DTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define DTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dts_pkg.sv -----
package dts_pkg;

    // Special characters
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_DQUOTE  = 8'd34;
    localparam logic [7:0] CH_HASH    = 8'd35;
    localparam logic [7:0] CH_SQUOTE  = 8'd39;
    localparam logic [7:0] CH_LPAREN  = 8'd40;
    localparam logic [7:0] CH_RPAREN  = 8'd41;
    localparam logic [7:0] CH_COMMA   = 8'd44;

    // Configuration register indexes
    localparam logic [1:0] CFG_USE_QUOTES     = 2'd0;
    localparam logic [1:0] CFG_STRIP_BRACKETS = 2'd1;
    localparam logic [1:0] CFG_SKIP_BLANKS    = 2'd2;

    // Byte classes
    typedef enum logic [2:0] {
        CLS_EOL,
        CLS_DELIM,
        CLS_DQUOTE,
        CLS_SQUOTE,
        CLS_BRACKET,
        CLS_HASH,
        CLS_OTHER
    } class_t;

    // Open quote kind
    typedef enum logic [1:0] {
        QUOTE_NONE,
        QUOTE_DOUBLE,
        QUOTE_SINGLE
    } quote_t;

    typedef struct packed {
        logic use_quotes;
        logic strip_brackets;
        logic skip_blanks;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       token_done;
        logic [4:0] token_index;
        logic       line_done;
        logic [5:0] token_count;
        logic       overflow;
    } result_t;

endpackage

// ----- design/delimited_token_splitter.sv -----
// Byte-serial line tokenizer, one result per input byte.
// Pipeline: input register, then result register; output back-pressure can stall both.
// One byte per cycle unless m_tready stalls; running token state updates once per byte.
// Reset (rst_n low, asynchronous): pipeline empty, configuration and line state cleared.
// No clearing pass: the block accepts input in the first cycle after reset.
`include "delimited_token_splitter_defines.svh"
module delimited_token_splitter #(
    parameter int MAX_TOKEN_LEN = 64,
    parameter int MAX_TOKENS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // buffer_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_char, [8] char_valid, [9] token_done,
                                   // [14:10] token_index, [20:15] token_count,
                                   // [21] overflow, [23:22] zero
    output logic        m_tlast    // line_done
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int CNT_W = $clog2(MAX_TOKENS + 1);

    dts_pkg::cfg_t    cfg_reg;
    logic             s1_valid_reg;
    logic [7:0]       s1_char_reg;
    logic             s1_last_reg;
    logic             m_valid_reg;
    dts_pkg::result_t res_reg;

    dts_pkg::quote_t  quote_reg;
    dts_pkg::quote_t  quote_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             comment_reg;
    logic             comment_next;
    logic [CNT_W-1:0] tokens_reg;
    logic [CNT_W-1:0] tokens_next;
    dts_pkg::result_t res_next;
    dts_pkg::class_t  char_class;

    logic             s2_ready;
    logic             s1_move;
    logic             in_acc;

    // Handshake
    assign s2_ready = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && s2_ready;
    assign s_tready = !s1_valid_reg || s2_ready;
    assign in_acc   = s_tvalid && s_tready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                dts_pkg::CFG_USE_QUOTES:     cfg_reg.use_quotes     <= cfg_data;
                dts_pkg::CFG_STRIP_BRACKETS: cfg_reg.strip_brackets <= cfg_data;
                dts_pkg::CFG_SKIP_BLANKS:    cfg_reg.skip_blanks    <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Pipeline valids and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            quote_reg    <= dts_pkg::QUOTE_NONE;
            len_reg      <= '0;
            comment_reg  <= 1'b0;
            tokens_reg   <= '0;
        end
        else
        begin
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            if (s1_move)
            begin
                quote_reg   <= quote_next;
                len_reg     <= len_next;
                comment_reg <= comment_next;
                tokens_reg  <= tokens_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_char_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        if (s1_move)
            res_reg <= res_next;
    end

    dts_classify u_classify (
        .char_byte  (s1_char_reg),
        .char_class (char_class)
    );

    dts_step #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .MAX_TOKENS    (MAX_TOKENS),
        .LEN_W         (LEN_W),
        .CNT_W         (CNT_W)
    ) u_step (
        .char_class  (char_class),
        .char_byte   (s1_char_reg),
        .buffer_last (s1_last_reg),
        .cfg         (cfg_reg),
        .quote_cur   (quote_reg),
        .len_cur     (len_reg),
        .comment_cur (comment_reg),
        .tokens_cur  (tokens_reg),
        .quote_nxt   (quote_next),
        .len_nxt     (len_next),
        .comment_nxt (comment_next),
        .tokens_nxt  (tokens_next),
        .result      (res_next)
    );

    // Output packing
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = res_reg.line_done;
    assign m_tdata  = {2'b00, res_reg.overflow, res_reg.token_count, res_reg.token_index,
                       res_reg.token_done, res_reg.char_valid, res_reg.out_char};

    // Checks
    `DTS_ASSERT_NOW(a_tokens_range, 1'b1, tokens_reg <= CNT_W'(MAX_TOKENS), "token count past limit")
    `DTS_ASSERT_NOW(a_len_range, 1'b1, len_reg <= LEN_W'(MAX_TOKEN_LEN), "token length past limit")
    `DTS_ASSERT_NOW(a_comment_quote, comment_reg, quote_reg == dts_pkg::QUOTE_NONE, "quote open in comment")
    `DTS_ASSERT_NOW(a_valid_no_over, m_valid_reg && res_reg.char_valid, !res_reg.overflow, "char passed and dropped")
    `DTS_ASSERT_NEXT(a_line_clears, s1_move && res_next.line_done, tokens_reg == '0, "line end kept tokens")

endmodule

// ----- design/dts_classify.sv -----
// Sorts one raw byte into the classes the tokenizer reacts to
module dts_classify (
    input  logic [7:0]      char_byte,
    output dts_pkg::class_t char_class
);

    always_comb
    begin
        case (char_byte) inside
            dts_pkg::CH_LF, dts_pkg::CH_CR:                      char_class = dts_pkg::CLS_EOL;
            dts_pkg::CH_TAB, dts_pkg::CH_SPACE, dts_pkg::CH_COMMA: char_class = dts_pkg::CLS_DELIM;
            dts_pkg::CH_DQUOTE:                                  char_class = dts_pkg::CLS_DQUOTE;
            dts_pkg::CH_SQUOTE:                                  char_class = dts_pkg::CLS_SQUOTE;
            dts_pkg::CH_LPAREN, dts_pkg::CH_RPAREN:              char_class = dts_pkg::CLS_BRACKET;
            dts_pkg::CH_HASH:                                    char_class = dts_pkg::CLS_HASH;
            default:                                             char_class = dts_pkg::CLS_OTHER;
        endcase
    end

endmodule

// ----- design/dts_step.sv -----
// Next-state and result logic for one byte
module dts_step #(
    parameter int MAX_TOKEN_LEN = 64,
    parameter int MAX_TOKENS    = 32,
    parameter int LEN_W         = 7,
    parameter int CNT_W         = 6
) (
    input  dts_pkg::class_t  char_class,
    input  logic [7:0]       char_byte,
    input  logic             buffer_last,
    input  dts_pkg::cfg_t    cfg,
    input  dts_pkg::quote_t  quote_cur,
    input  logic [LEN_W-1:0] len_cur,
    input  logic             comment_cur,
    input  logic [CNT_W-1:0] tokens_cur,
    output dts_pkg::quote_t  quote_nxt,
    output logic [LEN_W-1:0] len_nxt,
    output logic             comment_nxt,
    output logic [CNT_W-1:0] tokens_nxt,
    output dts_pkg::result_t result
);

    dts_pkg::quote_t  quote_b;
    dts_pkg::quote_t  kind;
    logic             comment_b;
    logic             append;
    logic             fin_byte;
    logic             fin_last;
    logic             finish;
    logic             eol_byte;
    logic             line_end;
    logic             tok_full;
    logic             len_full;
    logic [LEN_W-1:0] len_a;
    logic [LEN_W-1:0] len_b;
    logic [CNT_W-1:0] tokens_a;
    logic [CNT_W-1:0] idx;
    logic [31:0]      idx_ext;
    logic [31:0]      cnt_ext;

    assign tok_full = tokens_cur >= CNT_W'(MAX_TOKENS);
    assign len_full = len_cur >= LEN_W'(MAX_TOKEN_LEN);
    assign kind     = (char_class == dts_pkg::CLS_DQUOTE) ? dts_pkg::QUOTE_DOUBLE
                                                          : dts_pkg::QUOTE_SINGLE;

    // Byte decision
    always_comb
    begin
        quote_b   = quote_cur;
        comment_b = comment_cur;
        append    = 1'b0;
        fin_byte  = 1'b0;
        eol_byte  = 1'b0;
        if (comment_cur)
        begin
            eol_byte = (char_class == dts_pkg::CLS_EOL);
        end
        else
        begin
            case (char_class)
                dts_pkg::CLS_EOL:
                begin
                    fin_byte = (len_cur != '0);
                    eol_byte = 1'b1;
                end
                dts_pkg::CLS_DELIM:
                begin
                    if (quote_cur != dts_pkg::QUOTE_NONE)
                        append = 1'b1;
                    else
                        fin_byte = (len_cur != '0);
                end
                dts_pkg::CLS_DQUOTE, dts_pkg::CLS_SQUOTE:
                begin
                    if (cfg.use_quotes)
                    begin
                        if (quote_cur == dts_pkg::QUOTE_NONE)
                            quote_b = kind;
                        else if (quote_cur == kind)
                        begin
                            quote_b  = dts_pkg::QUOTE_NONE;
                            fin_byte = 1'b1;
                        end
                        else
                            append = 1'b1;
                    end
                end
                dts_pkg::CLS_BRACKET:
                begin
                    append = !cfg.strip_brackets;
                end
                dts_pkg::CLS_HASH:
                begin
                    fin_byte  = (len_cur != '0);
                    quote_b   = dts_pkg::QUOTE_NONE;
                    comment_b = 1'b1;
                end
                default:
                begin
                    append = 1'b1;
                end
            endcase
        end
    end

    // Length after append / byte-driven finish; length saturates at the limit
    assign len_a = (append && !len_full) ? len_cur + LEN_W'(1) : len_cur;
    assign len_b = fin_byte ? '0 : len_a;

    // Flagged last byte closes a pending token
    assign fin_last = buffer_last && !eol_byte && !comment_b && (len_b != '0);
    assign finish   = fin_byte || fin_last;
    assign line_end = eol_byte || buffer_last;

    assign tokens_a = (finish && !tok_full) ? tokens_cur + CNT_W'(1) : tokens_cur;
    assign idx      = tok_full ? CNT_W'(MAX_TOKENS - 1) : tokens_cur;
    assign idx_ext  = 32'(idx);
    assign cnt_ext  = 32'(tokens_a);

    // Result item
    always_comb
    begin
        result.out_char    = (append && !tok_full && !len_full) ? char_byte : 8'd0;
        result.char_valid  = append && !tok_full && !len_full;
        result.token_done  = finish && !tok_full;
        result.token_index = idx_ext[4:0];
        result.line_done   = line_end && !(cfg.skip_blanks && (tokens_a == '0));
        result.token_count = cnt_ext[5:0];
        result.overflow    = (append && (tok_full || len_full)) || (finish && tok_full);
    end

    // State after this byte
    always_comb
    begin
        if (line_end)
        begin
            quote_nxt   = dts_pkg::QUOTE_NONE;
            len_nxt     = '0;
            comment_nxt = 1'b0;
            tokens_nxt  = '0;
        end
        else
        begin
            quote_nxt   = quote_b;
            len_nxt     = fin_last ? '0 : len_b;
            comment_nxt = comment_b;
            tokens_nxt  = tokens_a;
        end
    end

endmodule

// ----- dv/delimited_token_splitter_tb.sv -----
module delimited_token_splitter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TOKEN_LEN     = 64;
    localparam int MAX_TOKENS        = 32;
    localparam int ITEMS_PER_SETTING = 120;
    localparam int DRAIN_CYCLES      = 4;

    // One text byte as it goes into the block
    typedef struct {
        logic [7:0] c;
        logic       last;
    } text_byte_t;

    // Directed row: configuration, byte, and optionally a hand-written result
    typedef struct {
        dts_pkg::cfg_t    cfg;
        logic [7:0]       c;
        logic             last;
        logic             typed;
        dts_pkg::result_t res;
    } dir_row_t;

    // Settings walked by the random part, extremes included
    localparam dts_pkg::cfg_t SETTING_PLAN [6] =
        '{3'b111, 3'b000, 3'b101, 3'b010, 3'b110, 3'b011};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    int send_idle = 14;
    int recv_idle = 47;
    int mismatch_count = 0;

    // Predicted per-byte results, oldest first
    dts_pkg::result_t pending_results [$];
    text_byte_t       text_q [$];
    dir_row_t         dir_rows [$];

    // Tokenizer state as the testbench sees it
    dts_pkg::cfg_t    cur_cfg = '0;
    dts_pkg::quote_t  quote_state = dts_pkg::QUOTE_NONE;
    int               tok_len = 0;
    int               line_tokens = 0;
    logic             in_comment = 1'b0;
    dts_pkg::result_t step_res;

    delimited_token_splitter #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
        .MAX_TOKENS   (MAX_TOKENS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Append a character, saturating on token length and token count
    function automatic void add_char(input logic [7:0] c);
        if (line_tokens >= MAX_TOKENS)
        begin
            step_res.overflow = 1'b1;
            if (tok_len < MAX_TOKEN_LEN)
                tok_len++;
        end
        else if (tok_len >= MAX_TOKEN_LEN)
            step_res.overflow = 1'b1;
        else
        begin
            step_res.out_char   = c;
            step_res.char_valid = 1'b1;
            tok_len++;
        end
    endfunction

    // Close the current token; past the token limit it is dropped
    function automatic void end_token();
        if (line_tokens < MAX_TOKENS)
        begin
            step_res.token_done = 1'b1;
            line_tokens++;
        end
        else
            step_res.overflow = 1'b1;
        tok_len = 0;
    endfunction

    // Expected result of one accepted byte, advancing the line state
    function automatic dts_pkg::result_t tokenize_byte(input logic [7:0] c, input logic last);
        logic            eol;
        dts_pkg::quote_t kind;
        step_res = '0;
        eol = 1'b0;
        step_res.token_index = (line_tokens < MAX_TOKENS) ? line_tokens[4:0]
                                                          : 5'(MAX_TOKENS - 1);
        if (in_comment)
            eol = (c == dts_pkg::CH_LF) || (c == dts_pkg::CH_CR);
        else
        begin
            case (c)
                dts_pkg::CH_LF, dts_pkg::CH_CR:
                begin
                    if (tok_len != 0)
                        end_token();
                    eol = 1'b1;
                end
                dts_pkg::CH_TAB, dts_pkg::CH_SPACE, dts_pkg::CH_COMMA:
                begin
                    if (quote_state != dts_pkg::QUOTE_NONE)
                        add_char(c);
                    else if (tok_len != 0)
                        end_token();
                end
                dts_pkg::CH_DQUOTE, dts_pkg::CH_SQUOTE:
                begin
                    if (cur_cfg.use_quotes)
                    begin
                        kind = (c == dts_pkg::CH_DQUOTE) ? dts_pkg::QUOTE_DOUBLE
                                                         : dts_pkg::QUOTE_SINGLE;
                        if (quote_state == dts_pkg::QUOTE_NONE)
                            quote_state = kind;
                        else if (quote_state == kind)
                        begin
                            // matching quote: token counts even when empty
                            quote_state = dts_pkg::QUOTE_NONE;
                            end_token();
                        end
                        else
                            add_char(c);
                    end
                end
                dts_pkg::CH_LPAREN, dts_pkg::CH_RPAREN:
                begin
                    if (!cur_cfg.strip_brackets)
                        add_char(c);
                end
                dts_pkg::CH_HASH:
                begin
                    if (tok_len != 0)
                        end_token();
                    quote_state = dts_pkg::QUOTE_NONE;
                    in_comment  = 1'b1;
                end
                default:
                    add_char(c);
            endcase
        end
        // flagged last byte: byte first, then the line ends
        if (last && !eol)
        begin
            if (!in_comment && tok_len != 0)
                end_token();
            eol = 1'b1;
        end
        step_res.token_count = line_tokens[5:0];
        if (eol)
        begin
            step_res.line_done = !(cur_cfg.skip_blanks && line_tokens == 0);
            line_tokens = 0;
            tok_len     = 0;
            quote_state = dts_pkg::QUOTE_NONE;
            in_comment  = 1'b0;
        end
        return step_res;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void add_row(input dts_pkg::cfg_t cfg, input logic [7:0] c,
                                    input logic last, input logic typed,
                                    input dts_pkg::result_t res);
        dir_row_t row;
        row.cfg   = cfg;
        row.c     = c;
        row.last  = last;
        row.typed = typed;
        row.res   = res;
        dir_rows.push_back(row);
    endfunction

    function automatic void push_byte(input logic [7:0] c, input logic last);
        text_byte_t b;
        b.c    = c;
        b.last = last;
        text_q.push_back(b);
    endfunction

    function automatic logic [7:0] rand_delim();
        case ($urandom_range(2))
            0:       return dts_pkg::CH_SPACE;
            1:       return dts_pkg::CH_TAB;
            default: return dts_pkg::CH_COMMA;
        endcase
    endfunction

    // Mostly letters; now and then brackets, quotes, delimiters, zero and high bytes
    function automatic logic [7:0] rand_text_byte();
        case ($urandom_range(19))
            0:       return $urandom_range(1) ? dts_pkg::CH_LPAREN : dts_pkg::CH_RPAREN;
            1:       return rand_delim();
            2:       return 8'($urandom_range(128, 255));
            3:       return 8'h00;
            4:       return $urandom_range(1) ? dts_pkg::CH_DQUOTE : dts_pkg::CH_SQUOTE;
            default: return 8'("a" + $urandom_range(25));
        endcase
    endfunction

    // One line of text: mostly well-formed tokens, sometimes raw noise
    task automatic gen_line();
        int         n_tok;
        int         len;
        logic       quoted;
        logic [7:0] qch;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 12))
                push_byte(8'($urandom), $urandom_range(7) == 0);
            return;
        end
        n_tok = ($urandom_range(11) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
        for (int t = 0; t < n_tok; t++)
        begin
            repeat ($urandom_range(0, 2))
                push_byte(rand_delim(), 1'b0);
            len = ($urandom_range(24) == 0 && n_tok < 8) ? $urandom_range(60, 70)
                                                           : $urandom_range(0, 8);
            quoted = ($urandom_range(4) == 0);
            qch = $urandom_range(1) ? dts_pkg::CH_DQUOTE : dts_pkg::CH_SQUOTE;
            if (quoted)
                push_byte(qch, 1'b0);
            repeat (len)
                push_byte(rand_text_byte(), 1'b0);
            if (quoted && $urandom_range(7) != 0)
                push_byte(qch, 1'b0);
            push_byte(rand_delim(), 1'b0);
        end
        // line terminator
        case ($urandom_range(3))
            0: push_byte(dts_pkg::CH_LF, 1'b0);
            1: push_byte(dts_pkg::CH_CR, 1'b0);
            2:
            begin
                push_byte(dts_pkg::CH_HASH, 1'b0);
                repeat ($urandom_range(0, 6))
                    push_byte(rand_text_byte(), 1'b0);
                push_byte(dts_pkg::CH_LF, 1'b0);
            end
            default: push_byte(rand_text_byte(), 1'b1);
        endcase
    endtask

    // Offer one byte with random gaps and wait for the request to be taken
    task automatic send_byte(input text_byte_t b);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b.c;
        s_tlast  <= b.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Registers change only with the block drained
    task automatic write_cfg(input dts_pkg::cfg_t next);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= dts_pkg::CFG_USE_QUOTES;
        cfg_data  <= next.use_quotes;
        @(posedge clk);
        cfg_index <= dts_pkg::CFG_STRIP_BRACKETS;
        cfg_data  <= next.strip_brackets;
        @(posedge clk);
        cfg_index <= dts_pkg::CFG_SKIP_BLANKS;
        cfg_data  <= next.skip_blanks;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_cfg = next;
    endtask

    // Result side: random stalls and in-order comparison
    always @(posedge clk)
    begin : result_monitor
        dts_pkg::result_t want;
        dts_pkg::result_t got;
        m_tready <= ($urandom_range(99) >= recv_idle);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.out_char    = m_tdata[7:0];
            got.char_valid  = m_tdata[8];
            got.token_done  = m_tdata[9];
            got.token_index = m_tdata[14:10];
            got.token_count = m_tdata[20:15];
            got.overflow    = m_tdata[21];
            got.line_done   = m_tlast;
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_char", want.out_char, got.out_char);
                check_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
                check_field("token_done", 8'(want.token_done), 8'(got.token_done));
                check_field("token_index", 8'(want.token_index), 8'(got.token_index));
                check_field("line_done", 8'(want.line_done), 8'(got.line_done));
                check_field("token_count", 8'(want.token_count), 8'(got.token_count));
                check_field("overflow", 8'(want.overflow), 8'(got.overflow));
                check_field("tdata_pad", 8'h00, 8'(m_tdata[23:22]));
            end
        end
    end

    initial
    begin
        #500us;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        dts_pkg::cfg_t    plain;
        dts_pkg::cfg_t    all_on;
        dts_pkg::result_t res_first;
        dts_pkg::result_t res_blank;
        dts_pkg::result_t pred;
        text_byte_t       b;

        plain  = '0;
        all_on = 3'b111;
        res_first = '0;
        res_first.out_char   = "a";
        res_first.char_valid = 1'b1;
        res_blank = '0;
        res_blank.line_done = 1'b1;

        // Reset settings: zero byte, quotes dropped, brackets kept, last flag, comment
        add_row(plain, "a", 1'b0, 1'b1, res_first);
        add_row(plain, 8'h00, 1'b0, 1'b0, '0);
        add_row(plain, dts_pkg::CH_SPACE, 1'b0, 1'b0, '0);
        add_row(plain, dts_pkg::CH_DQUOTE, 1'b0, 1'b0, '0);
        add_row(plain, dts_pkg::CH_LPAREN, 1'b0, 1'b0, '0);
        add_row(plain, 8'hFF, 1'b1, 1'b0, '0);
        add_row(plain, dts_pkg::CH_LF, 1'b0, 1'b1, res_blank);
        add_row(plain, "x", 1'b0, 1'b0, '0);
        add_row(plain, dts_pkg::CH_HASH, 1'b0, 1'b0, '0);
        add_row(plain, "y", 1'b0, 1'b0, '0);
        add_row(plain, dts_pkg::CH_CR, 1'b0, 1'b0, '0);
        // All options on: blank line hidden, quoted runs, empty quoted token,
        // stripped bracket, line end inside quotes, hash closing a quote
        add_row(all_on, dts_pkg::CH_LF, 1'b0, 1'b1, '0);
        add_row(all_on, dts_pkg::CH_DQUOTE, 1'b0, 1'b0, '0);
        add_row(all_on, dts_pkg::CH_COMMA, 1'b0, 1'b0, '0);
        add_row(all_on, dts_pkg::CH_SQUOTE, 1'b0, 1'b0, '0);
        add_row(all_on, dts_pkg::CH_DQUOTE, 1'b0, 1'b0, '0);
        add_row(all_on, dts_pkg::CH_SQUOTE, 1'b0, 1'b0, '0);
        add_row(all_on, dts_pkg::CH_SQUOTE, 1'b0, 1'b0, '0);
        add_row(all_on, dts_pkg::CH_RPAREN, 1'b0, 1'b0, '0);
        add_row(all_on, dts_pkg::CH_DQUOTE, 1'b0, 1'b0, '0);
        add_row(all_on, "q", 1'b0, 1'b0, '0);
        add_row(all_on, dts_pkg::CH_LF, 1'b0, 1'b0, '0);
        add_row(all_on, dts_pkg::CH_DQUOTE, 1'b0, 1'b0, '0);
        add_row(all_on, dts_pkg::CH_HASH, 1'b0, 1'b0, '0);
        add_row(all_on, dts_pkg::CH_TAB, 1'b1, 1'b1, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg != cur_cfg)
                write_cfg(dir_rows[i].cfg);
            b.c    = dir_rows[i].c;
            b.last = dir_rows[i].last;
            send_byte(b);
            pred = tokenize_byte(b.c, b.last);
            pending_results.push_back(dir_rows[i].typed ? dir_rows[i].res : pred);
        end

        // Random lines: two settings per idling pattern
        for (int ph = 0; ph < 6; ph++)
        begin
            int sent;
            send_idle = (ph < 2) ? 14 : (ph < 4) ? 47 : 0;
            recv_idle = (ph < 2) ? 47 : (ph < 4) ? 14 : 0;
            write_cfg(SETTING_PLAN[ph]);
            sent = 0;
            while (sent < ITEMS_PER_SETTING)
            begin
                gen_line();
                while (text_q.size() != 0)
                begin
                    b = text_q.pop_front();
                    send_byte(b);
                    pending_results.push_back(tokenize_byte(b.c, b.last));
                    sent++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
